// File: rtl/jdc_pkg.sv
// ----------------------------------------------------------------------------
// jdc_pkg: shared constants, types and tables
// Constants of the day-number to calendar conversion, field widths of the
// result beat and the stage-advance bundle used by the constant dividers.
// ----------------------------------------------------------------------------
package jdc_pkg;

  // default fixed-point split of the Julian date
  localparam int DAY_BITS_DEF  = 24;
  localparam int FRAC_BITS_DEF = 20;

  // result field widths
  localparam int YEAR_W   = 17;
  localparam int MONTH_W  = 4;
  localparam int DAY_W    = 5;
  localparam int HOUR_W   = 5;
  localparam int MINUTE_W = 6;
  localparam int SECOND_W = 6;
  localparam int WDAY_W   = 3;

  // first day number of the Gregorian calendar
  localparam int unsigned GREG_START = 32'd2299161;

  // alpha = (4z - ALPHA_OFS) / ALPHA_DIV
  localparam int unsigned ALPHA_OFS = 32'd7468865;
  localparam int unsigned ALPHA_DIV = 32'd146097;

  // b = a + B_OFS, c = (20b - C_OFS) / C_DIV, dd = DD_MUL * c / 4
  localparam int unsigned B_OFS  = 32'd1524;
  localparam int unsigned C_OFS  = 32'd2442;
  localparam int unsigned C_DIV  = 32'd7305;
  localparam int unsigned DD_MUL = 32'd1461;

  // year offsets for months after February and for January/February
  localparam int unsigned YEAR_OFS_LATE  = 32'd4716;
  localparam int unsigned YEAR_OFS_EARLY = 32'd4715;
  localparam int unsigned MONTH_FEB      = 32'd2;

  // month index e at which the month wraps into the next year
  localparam int unsigned E_WRAP = 32'd14;

  // twice the seconds per day, and seconds/minutes per step
  localparam int unsigned SEC_SCALE = 32'd172800;
  localparam int unsigned SEC_DIV   = 32'd60;

  // width of the day-of-year remainder b - dd (holds 123..488)
  localparam int REM_W = 9;

  // width of the octal digit sum of the day number (up to eleven digits)
  localparam int WD_SUM_W = 7;

  // e counts the thresholds ceil(30.6001 * k), k = 1..15, that rem reaches
  localparam int E_THR_N = 15;
  localparam logic [REM_W-1:0] E_THR [E_THR_N] = '{
    9'd31,  9'd62,  9'd92,  9'd123, 9'd154, 9'd184, 9'd215, 9'd245,
    9'd276, 9'd307, 9'd337, 9'd368, 9'd398, 9'd429, 9'd460
  };

  // floor(30.6001 * e) for the month index e
  function automatic logic [REM_W-1:0] month_ofs(input logic [3:0] e);
    logic [REM_W-1:0] r;
    case (e)
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd183;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd244;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd336;
      4'd12:   r = 9'd367;
      4'd13:   r = 9'd397;
      4'd14:   r = 9'd428;
      4'd15:   r = 9'd459;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

  // load enables of the estimate and correction stages of a divider
  typedef struct packed {
    logic est;
    logic cor;
  } jdc_adv_t;

endpackage

// File: rtl/jdc_in_if.sv
// ----------------------------------------------------------------------------
// jdc_in_if: Julian date channel
// Valid/ready channel carrying one fixed-point Julian date per beat.
// ----------------------------------------------------------------------------
interface jdc_in_if #(
  parameter int JW = jdc_pkg::DAY_BITS_DEF + jdc_pkg::FRAC_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic [JW-1:0] julian_date;

  modport source (output valid, output julian_date, input ready);
  modport sink   (input valid, input julian_date, output ready);
endinterface

// File: rtl/jdc_out_if.sv
// ----------------------------------------------------------------------------
// jdc_out_if: calendar result channel
// Valid/ready channel carrying date, time of day and weekday per beat.
// ----------------------------------------------------------------------------
interface jdc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [jdc_pkg::YEAR_W-1:0]    year;
  logic        [jdc_pkg::MONTH_W-1:0]   month;
  logic        [jdc_pkg::DAY_W-1:0]     day;
  logic        [jdc_pkg::HOUR_W-1:0]    hour;
  logic        [jdc_pkg::MINUTE_W-1:0]  minute;
  logic        [jdc_pkg::SECOND_W-1:0]  second;
  logic        [jdc_pkg::WDAY_W-1:0]    weekday;

  modport source (
    output valid, output year, output month, output day, output hour,
    output minute, output second, output weekday, input ready
  );
  modport sink (
    input valid, input year, input month, input day, input hour,
    input minute, input second, input weekday, output ready
  );
endinterface

// File: rtl/jdc_cdiv.sv
// ----------------------------------------------------------------------------
// jdc_cdiv: two-stage divider by a constant
// Stage one estimates x / K by a reciprocal multiply (off by at most one
// low), stage two forms the remainder and corrects quotient and remainder.
// ----------------------------------------------------------------------------
module jdc_cdiv #(
  parameter int  XW = 17,
  parameter int  K  = 60,
  localparam int RW = $clog2(K + 1),
  localparam int QW = XW - RW + 1
) (
  input  logic              clk_i,
  input  jdc_pkg::jdc_adv_t adv_i,
  input  logic [XW-1:0]     x_i,
  output logic [QW-1:0]     q_o,
  output logic [RW-1:0]     rem_o
);

  localparam logic [QW-1:0] MUL = QW'((64'd1 << XW) / 64'(K));
  localparam logic [XW-1:0] KX  = XW'(K);

  logic [XW+QW-1:0] prod_est;
  logic [XW-1:0]    x_q;
  logic [QW-1:0]    q0_q;
  logic [XW-1:0]    diff;
  logic             over;
  logic [QW-1:0]    q_d, q_q;
  logic [RW-1:0]    rem_d, rem_q;

  // estimate: floor(x * floor(2^XW / K) / 2^XW)
  assign prod_est = (XW+QW)'(x_i) * (XW+QW)'(MUL);

  always_ff @(posedge clk_i) begin
    if (adv_i.est) begin
      x_q  <= x_i;
      q0_q <= prod_est[XW+QW-1:XW];
    end
  end

  // correct: bump the quotient once when the remainder reaches K
  always_comb begin
    diff  = x_q - XW'(q0_q) * KX;
    over  = (diff >= KX);
    q_d   = over ? q0_q + QW'(1) : q0_q;
    rem_d = over ? RW'(diff - KX) : RW'(diff);
  end

  always_ff @(posedge clk_i) begin
    if (adv_i.cor) begin
      q_q   <= q_d;
      rem_q <= rem_d;
    end
  end

  assign q_o   = q_q;
  assign rem_o = rem_q;

endmodule

// File: rtl/julian_date_to_calendar.sv
// ----------------------------------------------------------------------------
// julian_date_to_calendar: Julian date to calendar date, time and weekday
//
//   channel  dir  payload                                         handshake
//   jd_i     in   julian_date (DAY_BITS.FRAC_BITS unsigned)       valid/ready
//   cal_o    out  year month day hour minute second weekday       valid/ready
//
// Eleven register stages; one beat enters per cycle unless a full pipeline
// is stalled at the output. The depth is set by the chain of two constant
// dividers (alpha, then c) with a multiply and correction stage each.
// Each stage carries a valid bit; a stage loads whenever it is empty or the
// stage after it moves, so bubbles collapse and a stalled result does not
// block new beats until the pipeline is full. Reset clears the valid bits
// only; there are no tables to fill.
// ----------------------------------------------------------------------------
module julian_date_to_calendar #(
  parameter int DAY_BITS  = jdc_pkg::DAY_BITS_DEF,
  parameter int FRAC_BITS = jdc_pkg::FRAC_BITS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  jdc_in_if.sink    jd_i,
  jdc_out_if.source cal_o
);

  localparam int NS   = 11;
  localparam int JW   = DAY_BITS + FRAC_BITS;
  localparam int ZW   = DAY_BITS + 1;
  localparam int XAW  = ZW + 2;
  localparam int AQW  = XAW - $clog2(jdc_pkg::ALPHA_DIV + 1) + 1;
  localparam int BW   = ZW + 1;
  localparam int YW   = ZW + 4;
  localparam int CQW  = YW - $clog2(jdc_pkg::C_DIV + 1) + 1;
  localparam int DDW  = CQW + 11;
  localparam int YCW  = (CQW > jdc_pkg::YEAR_W) ? CQW : jdc_pkg::YEAR_W;
  localparam int TPW  = FRAC_BITS + 18;
  localparam int SW   = 17;
  localparam int MTW  = SW - $clog2(jdc_pkg::SEC_DIV + 1) + 1;
  localparam int HQW  = MTW - $clog2(jdc_pkg::SEC_DIV + 1) + 1;
  localparam int NDIG = (ZW + 2) / 3;
  localparam int RW   = jdc_pkg::REM_W;

  localparam logic [JW:0]  HALF    = (JW+1)'(1) << (FRAC_BITS - 1);
  localparam logic [TPW-1:0] TOD_RND = TPW'(1) << FRAC_BITS;

  // stage control
  logic [NS:1]   v_q;
  logic [NS+1:1] adv;

  // date path
  logic [JW:0]            sh;
  logic [ZW-1:0]          z_q    [1:4];
  logic [FRAC_BITS-1:0]   frac_q;
  logic                   greg_q [2:4];
  logic [XAW-1:0]         xa_d, xa_q;
  logic [AQW-1:0]         alpha;
  logic [BW-1:0]          b_d;
  logic [BW-1:0]          b_q    [5:8];
  logic [YW-1:0]          y_d, y_q;
  logic [CQW-1:0]         c_div;
  logic [CQW-1:0]         c_q    [9:10];
  logic [DDW-1:0]         dd_prod;
  logic [RW-1:0]          rem_q  [9:10];
  logic [3:0]             e_cnt, e_q;
  logic [3:0]             mon;
  logic [YCW-1:0]         year_ofs, year_full;
  logic [jdc_pkg::YEAR_W-1:0]  year_q;
  logic [jdc_pkg::MONTH_W-1:0] month_q;
  logic [jdc_pkg::DAY_W-1:0]   day_q;

  // time-of-day path
  logic [TPW-1:0]               tod_prod;
  logic [SW-1:0]                secs_q;
  logic [MTW-1:0]               mt;
  logic [jdc_pkg::SECOND_W-1:0] sec_rem;
  logic [HQW-1:0]               hq;
  logic [jdc_pkg::MINUTE_W-1:0] min_rem;
  logic [jdc_pkg::SECOND_W-1:0] sec_q  [5:NS];
  logic [jdc_pkg::HOUR_W-1:0]   hour_q [7:NS];
  logic [jdc_pkg::MINUTE_W-1:0] min_q  [7:NS];

  // weekday path
  logic [3*NDIG-1:0]            zpad;
  logic [jdc_pkg::WD_SUM_W-1:0] dsum_d, dsum_q;
  logic [3:0]                   fold_t, fold_u;
  logic [jdc_pkg::WDAY_W-1:0]   wd_d;
  logic [jdc_pkg::WDAY_W-1:0]   wd_q [3:NS];

  // advance a stage when it is empty or its successor advances
  always_comb begin
    adv[NS+1] = cal_o.ready;
    for (int i = NS; i >= 1; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
  end

  assign jd_i.ready = adv[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[1]) v_q[1] <= jd_i.valid;
      for (int i = 2; i <= NS; i++) begin
        if (adv[i]) v_q[i] <= v_q[i-1];
      end
    end
  end

  // stage 1: add half a day, split into day number and fraction
  assign sh = (JW+1)'(jd_i.julian_date) + HALF;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      z_q[1] <= sh[JW:FRAC_BITS];
      frac_q <= sh[FRAC_BITS-1:0];
    end
  end

  // stage 2: alpha numerator, rounded seconds, octal digit sum of z
  always_comb begin
    xa_d     = '0;
    if (z_q[1] >= ZW'(jdc_pkg::GREG_START)) begin
      xa_d = {z_q[1], 2'b00} - XAW'(jdc_pkg::ALPHA_OFS);
    end
    tod_prod = TPW'(frac_q) * TPW'(jdc_pkg::SEC_SCALE) + TOD_RND;
    zpad     = (3*NDIG)'(z_q[1]);
    dsum_d   = '0;
    for (int d = 0; d < NDIG; d++) begin
      dsum_d = dsum_d + jdc_pkg::WD_SUM_W'(zpad[3*d +: 3]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      xa_q      <= xa_d;
      greg_q[2] <= (z_q[1] >= ZW'(jdc_pkg::GREG_START));
      z_q[2]    <= z_q[1];
      secs_q    <= tod_prod[TPW-1:FRAC_BITS+1];
      dsum_q    <= dsum_d;
    end
  end

  // stage 3: fold the digit sum down to z mod 7
  always_comb begin
    fold_t = 4'(dsum_q[2:0]) + 4'(dsum_q[5:3]) + 4'(dsum_q[6]);
    fold_u = 4'(fold_t[2:0]) + 4'(fold_t[3]);
    wd_d   = (fold_u >= 4'd7) ? jdc_pkg::WDAY_W'(fold_u - 4'd7)
                              : jdc_pkg::WDAY_W'(fold_u);
  end

  // stages 3-4: alpha and the minute count with its leftover seconds
  jdc_cdiv #(.XW(XAW), .K(jdc_pkg::ALPHA_DIV)) u_div_alpha (
    .clk_i (clk_i),
    .adv_i ('{est: adv[3], cor: adv[4]}),
    .x_i   (xa_q),
    .q_o   (alpha),
    .rem_o ()
  );

  jdc_cdiv #(.XW(SW), .K(jdc_pkg::SEC_DIV)) u_div_sec (
    .clk_i (clk_i),
    .adv_i ('{est: adv[3], cor: adv[4]}),
    .x_i   (secs_q),
    .q_o   (mt),
    .rem_o (sec_rem)
  );

  // stages 5-6: hours and minutes
  jdc_cdiv #(.XW(MTW), .K(jdc_pkg::SEC_DIV)) u_div_min (
    .clk_i (clk_i),
    .adv_i ('{est: adv[5], cor: adv[6]}),
    .x_i   (mt),
    .q_o   (hq),
    .rem_o (min_rem)
  );

  // stage 5: b = a + 1524 with the Gregorian correction
  always_comb begin
    b_d = BW'(z_q[4]) + BW'(jdc_pkg::B_OFS);
    if (greg_q[4]) begin
      b_d = b_d + BW'(1) + BW'(alpha) - BW'(alpha >> 2);
    end
  end

  // stage 6: c numerator 20b - 2442
  assign y_d = (YW'(b_q[5]) << 4) + (YW'(b_q[5]) << 2) - YW'(jdc_pkg::C_OFS);

  // stages 7-8: c = y / 7305
  jdc_cdiv #(.XW(YW), .K(jdc_pkg::C_DIV)) u_div_c (
    .clk_i (clk_i),
    .adv_i ('{est: adv[7], cor: adv[8]}),
    .x_i   (y_q),
    .q_o   (c_div),
    .rem_o ()
  );

  // stage 9: day of the shifted year; only its low bits are needed
  assign dd_prod = DDW'(c_div) * DDW'(jdc_pkg::DD_MUL);

  // stage 10: month index e from the threshold table
  always_comb begin
    e_cnt = '0;
    for (int k = 0; k < jdc_pkg::E_THR_N; k++) begin
      e_cnt = e_cnt + 4'(rem_q[9] >= jdc_pkg::E_THR[k]);
    end
  end

  // stage 11: month, year and day of month
  always_comb begin
    mon       = (e_q < 4'(jdc_pkg::E_WRAP)) ? e_q - 4'd1 : e_q - 4'd13;
    year_ofs  = (mon > 4'(jdc_pkg::MONTH_FEB)) ? YCW'(jdc_pkg::YEAR_OFS_LATE)
                                               : YCW'(jdc_pkg::YEAR_OFS_EARLY);
    year_full = YCW'(c_q[10]) - year_ofs;
  end

  // date payload registers
  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      z_q[3]    <= z_q[2];
      greg_q[3] <= greg_q[2];
    end
    if (adv[4]) begin
      z_q[4]    <= z_q[3];
      greg_q[4] <= greg_q[3];
    end
    if (adv[5]) begin
      b_q[5]    <= b_d;
    end
    if (adv[6]) begin
      b_q[6]    <= b_q[5];
      y_q       <= y_d;
    end
    if (adv[7]) begin
      b_q[7]    <= b_q[6];
    end
    if (adv[8]) begin
      b_q[8]    <= b_q[7];
    end
    if (adv[9]) begin
      c_q[9]    <= c_div;
      rem_q[9]  <= b_q[8][RW-1:0] - dd_prod[RW+1:2];
    end
    if (adv[10]) begin
      c_q[10]   <= c_q[9];
      rem_q[10] <= rem_q[9];
      e_q       <= e_cnt;
    end
    if (adv[11]) begin
      year_q    <= year_full[jdc_pkg::YEAR_W-1:0];
      month_q   <= mon;
      day_q     <= jdc_pkg::DAY_W'(rem_q[10] - jdc_pkg::month_ofs(e_q));
    end
  end

  // carry time of day and weekday alongside the date
  always_ff @(posedge clk_i) begin
    if (adv[3]) wd_q[3] <= wd_d;
    for (int i = 4; i <= NS; i++) begin
      if (adv[i]) wd_q[i] <= wd_q[i-1];
    end
    if (adv[5]) sec_q[5] <= sec_rem;
    for (int i = 6; i <= NS; i++) begin
      if (adv[i]) sec_q[i] <= sec_q[i-1];
    end
    if (adv[7]) begin
      hour_q[7] <= jdc_pkg::HOUR_W'(hq);
      min_q[7]  <= min_rem;
    end
    for (int i = 8; i <= NS; i++) begin
      if (adv[i]) begin
        hour_q[i] <= hour_q[i-1];
        min_q[i]  <= min_q[i-1];
      end
    end
  end

  // drive the result beat
  assign cal_o.valid   = v_q[NS];
  assign cal_o.year    = $signed(year_q);
  assign cal_o.month   = month_q;
  assign cal_o.day     = day_q;
  assign cal_o.hour    = hour_q[NS];
  assign cal_o.minute  = min_q[NS];
  assign cal_o.second  = sec_q[NS];
  assign cal_o.weekday = wd_q[NS];

endmodule
